/* rtl/core/rsr_pkg.sv */
package rsr_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam int PIX_W      = 8;
  localparam int IW_W       = 11;
  localparam int AX_W       = 10;
  localparam int TOL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COLUMN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASYMMETRIC_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_MODE      = 3'd4;

  localparam logic [IW_W-1:0]  RST_IMAGE_WIDTH      = 11'd640;
  localparam logic [AX_W-1:0]  RST_AXIS_COLUMN      = 10'd320;
  localparam logic [TOL_W-1:0] RST_TOLERANCE        = 8'd5;
  localparam logic [PIX_W-1:0] RST_ASYMMETRIC_VALUE = 8'd128;
  localparam logic             RST_REMOVE_MODE      = 1'b0;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [IW_W-1:0]  image_width;
    logic [AX_W-1:0]  axis_column;
    logic [TOL_W-1:0] tolerance;
    logic [PIX_W-1:0] asymmetric_value;
    logic             remove_mode;
  } rsr_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             asym;
    logic             row_last;
  } rsr_beat_t;

endpackage

/* rtl/core/rsr_front.sv */
module rsr_front #(
  parameter int MAX_WIDTH = rsr_pkg::DEF_MAX_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsr_pkg::rsr_cfg_t         cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rsr_pkg::PIX_W-1:0] in_pixel,
  input  logic                      in_flush,
  input  logic [rsr_pkg::QCNT_W-1:0] q_count,
  output logic                      beat_valid,
  output rsr_pkg::rsr_beat_t        beat
);
  import rsr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > IW_W) ? CW + 1 : IW_W;
  localparam int MW = (CW > AX_W) ? CW : AX_W;
  localparam int SW = MW + 2;
  localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);

  logic [PIX_W-1:0] mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_q;

  logic [CW-1:0]        col_r;
  logic                 have_prev_r;
  logic                 first_found_r;
  logic [CW-1:0]        first_col_r;
  logic                 right_found_r;
  logic [CW-1:0]        right_col_r;
  logic                 prev_active_r;
  logic signed [SW-1:0] prev_min_r;
  logic                 s1_valid_r;
  logic                 s1_asym_r;
  logic                 s1_last_r;

  logic [XW-1:0]        iw_x;
  logic [CW-1:0]        wm1;
  logic                 accept;
  logic                 take;
  logic [PIX_W-1:0]     pix;
  logic                 nz;
  logic                 is_last;
  logic [CW-1:0]        col;
  logic                 at_right;
  logic                 n_first_found;
  logic [CW-1:0]        n_first_col;
  logic                 n_right_found;
  logic [CW-1:0]        n_right_col;
  logic signed [SW-1:0] col_s;
  logic signed [SW-1:0] ax_s;
  logic signed [SW-1:0] left_len;
  logic signed [SW-1:0] right_len;
  logic signed [SW-1:0] min_len;
  logic signed [SW-1:0] axis_dist;
  logic signed [SW:0]   excess;
  logic signed [SW:0]   min_x;
  logic                 asym;
  logic [QCNT_W:0]      in_flight;

  // effective width minus one, clamped to 1..MAX_WIDTH
  assign iw_x = XW'(cfg.image_width);
  always_comb begin
    if (iw_x == '0) begin
      wm1 = '0;
    end else if (iw_x > MAXW_X) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(iw_x - XW'(1));
    end
  end

  assign in_flight = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_r);
  assign in_ready  = in_flight < (QCNT_W + 1)'(QDEPTH);
  assign accept    = in_valid && in_ready;
  // a flush with no buffered row is swallowed
  assign take      = accept && !(in_flush && !have_prev_r);

  assign pix     = in_flush ? '0 : in_pixel;
  assign nz      = pix != '0;
  assign is_last = col_r >= wm1;
  assign col     = is_last ? wm1 : col_r;

  assign at_right      = MW'(col) >= MW'(cfg.axis_column);
  assign n_first_found = first_found_r || nz;
  assign n_first_col   = (first_found_r || !nz) ? first_col_r : col;
  assign n_right_found = right_found_r || (nz && at_right);
  assign n_right_col   = (nz && at_right) ? col : right_col_r;

  assign col_s     = SW'(col);
  assign ax_s      = SW'(cfg.axis_column);
  assign left_len  = ax_s - SW'(n_first_col);
  assign right_len = n_right_found ? SW'(n_right_col) - ax_s : '0;
  assign min_len   = (left_len < right_len) ? left_len : right_len;

  // distance test against the stats of the buffered row
  assign axis_dist = (col_s >= ax_s) ? col_s - ax_s : ax_s - col_s;
  assign excess    = (SW + 1)'(axis_dist) - (SW + 1)'(cfg.tolerance);
  assign min_x     = (SW + 1)'(prev_min_r);
  assign asym      = prev_active_r && (excess > min_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      have_prev_r   <= 1'b0;
      first_found_r <= 1'b0;
      first_col_r   <= '0;
      right_found_r <= 1'b0;
      prev_active_r <= 1'b0;
      prev_min_r    <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      s1_valid_r <= take && have_prev_r;
      if (take) begin
        if (is_last) begin
          prev_active_r <= n_first_found;
          prev_min_r    <= min_len;
          have_prev_r   <= !in_flush;
          first_found_r <= 1'b0;
          first_col_r   <= '0;
          right_found_r <= 1'b0;
          col_r         <= '0;
        end else begin
          first_found_r <= n_first_found;
          first_col_r   <= n_first_col;
          right_found_r <= n_right_found;
          col_r         <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      right_col_r <= n_right_col;
      s1_asym_r   <= asym;
      s1_last_r   <= is_last;
    end
  end

  // read-before-write line store
  always_ff @(posedge clk) begin
    if (take) begin
      rd_q     <= mem[col];
      mem[col] <= pix;
    end
  end

  assign beat_valid    = s1_valid_r;
  assign beat.pixel    = rd_q;
  assign beat.asym     = s1_asym_r;
  assign beat.row_last = s1_last_r;

endmodule

/* rtl/core/rsr_queue.sv */
module rsr_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rsr_pkg::rsr_beat_t         push_beat,
  input  logic                       pop,
  output logic                       head_valid,
  output rsr_pkg::rsr_beat_t         head,
  output logic [rsr_pkg::QCNT_W-1:0] count
);
  import rsr_pkg::*;

  rsr_beat_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_beat;
    end
  end

endmodule

/* rtl/core/rsr_back.sv */
module rsr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsr_pkg::rsr_cfg_t         cfg,
  input  logic                      q_valid,
  input  rsr_pkg::rsr_beat_t        q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rsr_pkg::PIX_W-1:0] out_pixel,
  output logic                      out_last
);
  import rsr_pkg::*;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;
  logic [PIX_W-1:0] recol;
  logic [PIX_W:0]   lim;
  logic [PIX_W-1:0] result;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  assign recol = (q_head.asym && q_head.pixel != '0) ? cfg.asymmetric_value : q_head.pixel;
  assign lim   = {1'b0, cfg.asymmetric_value} + (PIX_W + 1)'(1);
  // remove mode drops anything brighter than the marker plus one
  assign result = (cfg.remove_mode && ({1'b0, recol} > lim)) ? '0 : recol;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_pixel_r <= result;
      out_last_r  <= q_head.row_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/core/row_symmetry_pixel_recolor.sv */
// channel | direction | beat contents
// in_     | input     | tdata: pixel_in[7:0]; tuser: flush
// out_    | output    | tdata: pixel_out[7:0]; tlast: row_last
// cfg_    | input     | we, index 0..4, wdata up to 11 bits, no read-back
//
// one pixel per cycle sustained while the queue has room; a result passes the line store read,
// queue and output register; the single-port line store sets the rate
// reset is synchronous and active low, takes effect at once, no clearing pass
// output lags input by one row; flush beats drain the buffered row
// in_tready drops once the queue and the read stage together hold four beats
module row_symmetry_pixel_recolor #(
  parameter int MAX_WIDTH = rsr_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] pixel_in
  input  logic                           in_tuser,   // [0] flush
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] pixel_out
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rsr_pkg::*;

  rsr_cfg_t          cfg_r;
  logic              beat_valid;
  rsr_beat_t         beat;
  logic              q_valid;
  rsr_beat_t         q_head;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width      <= RST_IMAGE_WIDTH;
      cfg_r.axis_column      <= RST_AXIS_COLUMN;
      cfg_r.tolerance        <= RST_TOLERANCE;
      cfg_r.asymmetric_value <= RST_ASYMMETRIC_VALUE;
      cfg_r.remove_mode      <= RST_REMOVE_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:      cfg_r.image_width      <= cfg_wdata[IW_W-1:0];
        CFG_AXIS_COLUMN:      cfg_r.axis_column      <= cfg_wdata[AX_W-1:0];
        CFG_TOLERANCE:        cfg_r.tolerance        <= cfg_wdata[TOL_W-1:0];
        CFG_ASYMMETRIC_VALUE: cfg_r.asymmetric_value <= cfg_wdata[PIX_W-1:0];
        CFG_REMOVE_MODE:      cfg_r.remove_mode      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  rsr_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .in_flush  (in_tuser),
    .q_count   (q_count),
    .beat_valid(beat_valid),
    .beat      (beat)
  );

  rsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (beat_valid),
    .push_beat (beat),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  rsr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pixel(out_tdata),
    .out_last (out_tlast)
  );

endmodule

/* test/testbench.sv */
module testbench;
  import rsr_pkg::*;

  localparam int MAXW        = DEF_MAX_WIDTH;
  localparam int CYCLE_LIMIT = 60000;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_last;
  } recolored_pixel_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;  // [7:0] pixel_in
  logic                  in_tuser   = 1'b0; // [0] flush
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;        // [7:0] pixel_out
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // register shadow
  int width_reg  = RST_IMAGE_WIDTH;
  int axis_reg   = RST_AXIS_COLUMN;
  int tol_reg    = RST_TOLERANCE;
  int asym_reg   = RST_ASYMMETRIC_VALUE;
  int remove_reg = RST_REMOVE_MODE;

  // row tracking state
  logic [7:0] line_buf [MAXW];
  int col_cnt    = 0;
  bit prev_valid = 1'b0;
  bit first_seen = 1'b0;
  int first_col  = 0;
  int last_right = -1;
  bit prev_active = 1'b0;
  int prev_min   = 0;

  recolored_pixel_t pending_pixels[$];

  int errors        = 0;
  int cycles        = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  row_symmetry_pixel_recolor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int eff_width(int w);
    return (w < 1) ? 1 : ((w > MAXW) ? MAXW : w);
  endfunction

  task automatic note_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // works out the recoloured pixel (if any) that an accepted beat releases
  task automatic track_pixel(logic [7:0] pix_in, logic fl);
    int w;
    int c;
    int d;
    int left;
    int right;
    logic [7:0] pix;
    logic [7:0] v;
    bit last;
    recolored_pixel_t r;
    w = eff_width(width_reg);
    if (fl && !prev_valid)
      return;
    pix = fl ? 8'd0 : pix_in;
    c = col_cnt;
    if (c >= w)
      c = w - 1;
    last = (c + 1 >= w);
    if (prev_valid) begin
      v = line_buf[c];
      d = c - axis_reg;
      if (d < 0)
        d = -d;
      if (prev_active && v != 8'd0 && d - tol_reg > prev_min)
        v = asym_reg[7:0];
      if (remove_reg != 0 && int'(v) > asym_reg + 1)
        v = 8'd0;
      r.pixel = v;
      r.row_last = last;
      pending_pixels.insert(pending_pixels.size(), r);
    end
    line_buf[c] = pix;
    if (pix != 8'd0) begin
      if (!first_seen) begin
        first_seen = 1'b1;
        first_col = c;
      end
      if (c >= axis_reg)
        last_right = c;
    end
    if (last) begin
      left = axis_reg - first_col;
      right = (last_right >= 0) ? last_right - axis_reg : 0;
      prev_active = first_seen;
      prev_min = (left < right) ? left : right;
      prev_valid = !fl;
      first_seen = 1'b0;
      first_col = 0;
      last_right = -1;
      col_cnt = 0;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic send_item(logic [7:0] pix, logic fl);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= fl;
    do @(posedge clk); while (!in_tready);
    track_pixel(pix, fl);
  endtask

  task automatic send_row6(logic [47:0] r);
    int i;
    for (i = 0; i < 6; i++)
      send_item(r[8*i +: 8], 1'b0);
  endtask

  // widening with a row buffered would read unwritten columns, so drain first
  task automatic apply_config(int w, int a, int t, int v, int rm);
    if (prev_valid && eff_width(w) > eff_width(width_reg))
      while (prev_valid)
        send_item(8'd0, 1'b1);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_AXIS_COLUMN;
    cfg_wdata <= a[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= t[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_ASYMMETRIC_VALUE;
    cfg_wdata <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_REMOVE_MODE;
    cfg_wdata <= rm[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg  = w & 11'h7ff;
    axis_reg   = a & 10'h3ff;
    tol_reg    = t & 8'hff;
    asym_reg   = v & 8'hff;
    remove_reg = rm & 1;
  endtask

  task automatic test_flush_ignored();
    repeat (3) send_item(8'hff, 1'b1);
  endtask

  task automatic test_row_shapes();
    apply_config(6, 2, 0, 100, 0);
    send_row6(48'h00_07_00_40_ff_01);
    send_row6(48'h00_00_00_00_00_00);  // blank row passes through
    send_row6(48'hff_80_00_00_00_00);  // first pixel past the axis
    send_row6(48'h00_00_00_00_33_ff);  // nothing at or past the axis
    send_row6(48'h80_01_02_02_01_80);
    send_row6(48'h00_00_00_11_00_00);  // lone pixel on the axis
    // flush mid-row, then the row ends on a flush beat
    send_item(8'h55, 1'b0);
    repeat (5) send_item(8'haa, 1'b1);
  endtask

  task automatic test_remove_mode();
    apply_config(6, 2, 0, 0, 1);
    send_row6(48'h02_01_ff_fe_01_02);
    send_row6(48'hff_ff_00_00_ff_ff);
    apply_config(6, 2, 255, 254, 1);
    send_row6(48'hff_fe_fd_01_00_ff);
    apply_config(6, 5, 1, 255, 1);
    send_row6(48'hff_ff_ff_ff_ff_ff);
    send_row6(48'h01_00_00_00_00_ff);
  endtask

  task automatic test_width_extremes();
    apply_config(1, 0, 0, 10, 0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h7f, 1'b0);
    send_item(8'h01, 1'b0);
    apply_config(0, 0, 3, 200, 1);  // clamps to one column
    send_item(8'hc9, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
  endtask

  task automatic test_width_cut();
    apply_config(6, 2, 1, 90, 0);
    send_row6(48'h09_00_40_ff_00_30);
    send_row6(48'h01_02_03_04_05_06);
    send_item(8'h11, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h22, 1'b0);
    // narrower than the current column: the next beat closes the row
    apply_config(2, 1, 0, 33, 0);
    send_item(8'h44, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h66, 1'b0);
    send_item(8'h77, 1'b0);
  endtask

  task automatic test_axis_beyond_row();
    apply_config(6, 1023, 0, 50, 0);
    send_row6(48'h00_00_01_00_00_ff);
    send_row6(48'hff_00_00_00_00_00);
    send_row6(48'h00_00_00_00_00_00);
    apply_config(6, 0, 2, 60, 0);
    send_row6(48'h00_ff_00_00_00_01);
    send_row6(48'hff_00_00_00_fe_00);
  endtask

  task automatic test_wide_rows();
    int i;
    apply_config(140, 70, 3, 77, 0);
    for (i = 0; i < 280; i++)
      send_item(($urandom_range(7) == 0) ? 8'($urandom_range(255, 1)) : 8'd0, 1'b0);
  endtask

  task automatic test_random_rows();
    int phase;
    int sent;
    int sel;
    int w;
    int a;
    int c;
    int lo;
    int hi;
    int spread;
    int style;
    logic [7:0] pix;
    logic fl;
    for (phase = 0; phase < 8; phase++) begin
      sel = $urandom_range(39);
      if (sel == 0)
        w = 0;
      else if (sel == 1)
        w = $urandom_range(300, 128);
      else if (sel < 6)
        w = $urandom_range(64, 25);
      else
        w = $urandom_range(20, 1);
      sel = $urandom_range(9);
      if (sel == 0)
        a = 1023;
      else if (sel == 1)
        a = 0;
      else
        a = $urandom_range(eff_width(w) + 1);
      apply_config(w, a,
                   ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(6),
                   $urandom_range(255), $urandom_range(1));
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      w = eff_width(width_reg);
      sent = 0;
      style = 1;
      lo = 0;
      hi = w - 1;
      while (sent < 40) begin
        c = col_cnt;
        if (c == 0) begin
          style = $urandom_range(9);
          spread = $urandom_range(w);
          if (style <= 4) begin
            // roughly balanced about the axis, with some jitter
            lo = axis_reg - spread - $urandom_range(2);
            hi = axis_reg + spread + $urandom_range(2);
          end else begin
            lo = $urandom_range(w - 1);
            hi = $urandom_range(w - 1, lo);
          end
        end
        if (style == 0)
          pix = 8'd0;
        else if (style >= 8)
          pix = 8'($urandom_range(255));
        else if (c >= lo && c <= hi)
          pix = ($urandom_range(9) != 0) ? 8'($urandom_range(255, 1)) : 8'd0;
        else
          pix = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 1)) : 8'd0;
        fl = ($urandom_range(29) == 0);
        if (!(fl && !prev_valid))
          sent++;
        send_item(pix, fl);
      end
    end
  endtask

  always @(posedge clk) begin : check_beats
    recolored_pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("beat with nothing expected: pixel %0d last %0d",
                                out_tdata, out_tlast));
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want.pixel)
          note_mismatch($sformatf("pixel_out %0d, expected %0d", out_tdata, want.pixel));
        if (out_tlast !== want.row_last)
          note_mismatch($sformatf("row_last %0d, expected %0d", out_tlast, want.row_last));
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_flush_ignored();
    test_row_shapes();
    test_remove_mode();
    test_width_extremes();
    test_width_cut();
    test_axis_beyond_row();
    test_wide_rows();
    test_random_rows();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (pending_pixels.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", pending_pixels.size()));
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
